// ===== hw/rtl/mbc_pkg.sv =====
`timescale 1ns / 1ps

package mbc_pkg;

   localparam int BlockW  = 64;
   localparam int HalfW   = 32;
   localparam int KeyRegs = 4;
   localparam int IndexW  = 3;
   localparam int PcW     = 4;
   localparam int PassW   = 2;
   localparam int RotL    = 11;

   localparam logic [IndexW-1:0] REG_KEY_0      = 3'd0;
   localparam logic [IndexW-1:0] REG_KEY_1      = 3'd1;
   localparam logic [IndexW-1:0] REG_KEY_2      = 3'd2;
   localparam logic [IndexW-1:0] REG_KEY_3      = 3'd3;
   localparam logic [IndexW-1:0] REG_BYTE_ORDER = 3'd4;

   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_FWD,
      JMP_REV
   } jump_type;

   typedef struct packed {
      logic [2:0] key_idx;
      logic       upd_a;
      jump_type   jump;
      logic [PcW-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic       load;
      logic       round_en;
      logic [2:0] key_idx;
      logic       upd_a;
      logic       drain;
   } ctl_type;

   localparam logic [PcW-1:0] PC_FWD = 4'd0;
   localparam logic [PcW-1:0] PC_REV = 4'd8;

   localparam logic [PassW-1:0] FWD_LAST_ENC = 2'd2;
   localparam logic [PassW-1:0] FWD_LAST_DEC = 2'd0;
   localparam logic [PassW-1:0] REV_LAST_ENC = 2'd0;
   localparam logic [PassW-1:0] REV_LAST_DEC = 2'd2;

   function automatic ucode_type ucode_rom(input logic [PcW-1:0] pc);
      ucode_type w;
      w.upd_a  = pc[0];
      w.jump   = JMP_NONE;
      w.target = PC_FWD;
      unique case (pc)
         4'd0:  w.key_idx = 3'd0;
         4'd1:  w.key_idx = 3'd1;
         4'd2:  w.key_idx = 3'd2;
         4'd3:  w.key_idx = 3'd3;
         4'd4:  w.key_idx = 3'd4;
         4'd5:  w.key_idx = 3'd5;
         4'd6:  w.key_idx = 3'd6;
         4'd7:  begin
            w.key_idx = 3'd7;
            w.jump    = JMP_FWD;
            w.target  = PC_FWD;
         end
         4'd8:  w.key_idx = 3'd7;
         4'd9:  w.key_idx = 3'd6;
         4'd10: w.key_idx = 3'd5;
         4'd11: w.key_idx = 3'd4;
         4'd12: w.key_idx = 3'd3;
         4'd13: w.key_idx = 3'd2;
         4'd14: w.key_idx = 3'd1;
         4'd15: begin
            w.key_idx = 3'd0;
            w.jump    = JMP_REV;
            w.target  = PC_REV;
         end
         default: w.key_idx = 3'd0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] sbox(input logic [2:0] row, input logic [3:0] x);
      logic [63:0] r;
      unique case (row)
         3'd0: r = 64'h1F30_7D8E_9B5A_264C;
         3'd1: r = 64'hF0DB_74E1_C5A9_3286;
         3'd2: r = 64'h069C_471E_DAF2_853B;
         3'd3: r = 64'hB9E3_5A07_6F4D_128C;
         3'd4: r = 64'hC24B_E390_D618_A5F7;
         3'd5: r = 64'h0E34_187B_AC29_6FD5;
         3'd6: r = 64'h73AD_0B4F_C196_52E8;
         3'd7: r = 64'h2BC9_6AF4_3850_DE71;
         default: r = '0;
      endcase
      return r[{x, 2'b00} +: 4];
   endfunction

   function automatic logic [HalfW-1:0] swap32(input logic [HalfW-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== hw/rtl/mbc_sequencer.sv =====
`timescale 1ns / 1ps

module mbc_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              dec,
   input  logic              out_free,
   output logic              idle,
   output mbc_pkg::ctl_type  ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [mbc_pkg::PcW-1:0]     pc_ff, pc_in;
   logic [mbc_pkg::PassW-1:0]   pass_ff, pass_in;
   logic                        dec_ff, dec_in;
   mbc_pkg::ucode_type          uw;
   logic [mbc_pkg::PassW-1:0]   fwd_last, rev_last;

   assign uw       = mbc_pkg::ucode_rom(pc_ff);
   assign fwd_last = dec_ff ? mbc_pkg::FWD_LAST_DEC : mbc_pkg::FWD_LAST_ENC;
   assign rev_last = dec_ff ? mbc_pkg::REV_LAST_DEC : mbc_pkg::REV_LAST_ENC;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      pass_in  = pass_ff;
      dec_in   = dec_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               pc_in    = mbc_pkg::PC_FWD;
               pass_in  = '0;
               dec_in   = dec;
            end
         end
         ST_RUN: begin
            unique case (uw.jump)
               mbc_pkg::JMP_NONE: pc_in = pc_ff + 1'b1;
               mbc_pkg::JMP_FWD: begin
                  if (pass_ff == fwd_last) begin
                     pc_in   = mbc_pkg::PC_REV;
                     pass_in = '0;
                  end else begin
                     pc_in   = uw.target;
                     pass_in = pass_ff + 1'b1;
                  end
               end
               mbc_pkg::JMP_REV: begin
                  if (pass_ff == rev_last) begin
                     state_in = ST_DONE;
                  end else begin
                     pc_in   = uw.target;
                     pass_in = pass_ff + 1'b1;
                  end
               end
               default: pc_in = pc_ff;
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         pass_ff  <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         pass_ff  <= pass_in;
         dec_ff   <= dec_in;
      end
   end

   assign idle         = (state_ff == ST_IDLE);
   assign ctl.load     = start && (state_ff == ST_IDLE);
   assign ctl.round_en = (state_ff == ST_RUN);
   assign ctl.key_idx  = uw.key_idx;
   assign ctl.upd_a    = uw.upd_a;
   assign ctl.drain    = (state_ff == ST_DONE) && out_free;

endmodule

// ===== hw/rtl/mbc_datapath.sv =====
`timescale 1ns / 1ps

module mbc_datapath (
   input  logic                                       clock,
   input  mbc_pkg::ctl_type                           ctl,
   input  logic [mbc_pkg::KeyRegs-1:0][mbc_pkg::BlockW-1:0] key,
   input  logic                                       le,
   input  logic [mbc_pkg::BlockW-1:0]                 block_in,
   output logic [mbc_pkg::BlockW-1:0]                 block_out
);

   logic [mbc_pkg::HalfW-1:0] a_ff, a_in, b_ff, b_in;
   logic [mbc_pkg::BlockW-1:0] kw;
   logic [mbc_pkg::HalfW-1:0] kraw, rk, src, sum, sub, f;

   assign kw   = key[ctl.key_idx[2:1]];
   assign kraw = ctl.key_idx[0] ? kw[31:0] : kw[63:32];
   assign rk   = le ? mbc_pkg::swap32(kraw) : kraw;
   assign src  = ctl.upd_a ? b_ff : a_ff;
   assign sum  = src + rk;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sub[4*i +: 4] = mbc_pkg::sbox(3'(i), sum[4*i +: 4]);
      end
   end

   assign f = {sub[mbc_pkg::HalfW-1-mbc_pkg::RotL:0],
               sub[mbc_pkg::HalfW-1 -: mbc_pkg::RotL]};

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      priority if (ctl.load) begin
         a_in = le ? mbc_pkg::swap32(block_in[63:32]) : block_in[31:0];
         b_in = le ? mbc_pkg::swap32(block_in[31:0])  : block_in[63:32];
      end else if (ctl.round_en) begin
         if (ctl.upd_a) begin
            a_in = a_ff ^ f;
         end else begin
            b_in = b_ff ^ f;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign block_out = le ? {mbc_pkg::swap32(b_ff), mbc_pkg::swap32(a_ff)} : {a_ff, b_ff};

endmodule

// ===== hw/rtl/magma_block_cipher.sv =====
`timescale 1ns / 1ps
// Magma (GOST 28147-89) block cipher, one 64-bit block per transaction.
// Channels:
//   csr_*  register writes: index 0..3 load the 256-bit key, index 4 picks
//          the byte order (0 big-endian Magma, 1 little-endian GOST).
//          Always ready; write only while no block is in flight.
//   req_*  one block and its action (0 encrypt, 1 decrypt).
//   rsp_*  the resulting block.
// Timing: the accept cycle loads the halves, then a microcoded sequencer
// steps the single round unit through 32 rounds, one per cycle, and the
// result then moves into the output register once that register is free.
// req_ready returns in the cycle the result is registered, so a new
// block can be taken while the previous result waits.
// Stall: if rsp_ready is low the finished block holds in the core and
// req_ready stays low until the output register frees up.
// Reset: clears the key, byte order, sequencer and output valid.
module magma_block_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbc_pkg::IndexW-1:0]         csr_index,
   input  logic [mbc_pkg::BlockW-1:0]         csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [mbc_pkg::BlockW-1:0]         req_block_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mbc_pkg::BlockW-1:0]         rsp_block_out
);

   logic [mbc_pkg::KeyRegs-1:0][mbc_pkg::BlockW-1:0] key_ff, key_in;
   logic                              le_ff, le_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mbc_pkg::BlockW-1:0]        rsp_data_ff, rsp_data_in;
   logic                              idle, start, out_free;
   logic [mbc_pkg::BlockW-1:0]        core_out;
   mbc_pkg::ctl_type                  ctl;

   assign csr_ready = 1'b1;
   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      key_in = key_ff;
      le_in  = le_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mbc_pkg::REG_KEY_0:      key_in[0] = csr_data;
            mbc_pkg::REG_KEY_1:      key_in[1] = csr_data;
            mbc_pkg::REG_KEY_2:      key_in[2] = csr_data;
            mbc_pkg::REG_KEY_3:      key_in[3] = csr_data;
            mbc_pkg::REG_BYTE_ORDER: le_in     = csr_data[0];
            default:                 le_in     = le_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (ctl.drain) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_out;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         le_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         le_ff        <= le_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   mbc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dec      (req_action == mbc_pkg::ACT_DECRYPT),
      .out_free (out_free),
      .idle     (idle),
      .ctl      (ctl)
   );

   mbc_datapath u_dp (
      .clock     (clock),
      .ctl       (ctl),
      .key       (key_ff),
      .le        (le_ff),
      .block_in  (req_block_in),
      .block_out (core_out)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_data_ff;

endmodule

// ===== hw/rtl/mbc_checker.sv =====
`timescale 1ns / 1ps

module mbc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [mbc_pkg::BlockW-1:0]         rsp_block_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after a transaction was taken");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after the request");

   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(req_ready) |-> rsp_valid)
      else $error("core freed without registering a result");

endmodule

bind magma_block_cipher mbc_checker u_mbc_checker (.*);
